// ===== hdl/rcp_pkg.sv =====
// shared types, constants and sine table builder for the rose curve polygon generator
package rcp_pkg;

  localparam int ANGLE_W = 14;
  localparam int COUNT_W = 15;
  localparam int HALF_W = 12;
  localparam int COORD_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_DIVISIONS = 16384;
  localparam int DEF_MIN_POINTS = 5;
  localparam int DEF_PHASE_BITS = 12;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISIONS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 2'd2;

  localparam logic [COUNT_W-1:0] DIVISIONS_RESET = 15'd360;
  localparam logic [HALF_W-1:0] HALF_WIDTH_RESET = 12'd320;
  localparam logic [HALF_W-1:0] HALF_HEIGHT_RESET = 12'd240;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    logic                op;
    logic [ANGLE_W-1:0]  multiplier;
    logic [ANGLE_W-1:0]  step;
  } rcp_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  point_count;
    logic                too_few;
    logic [COORD_W-1:0]  x_coord;
    logic [COORD_W-1:0]  y_coord;
    logic                last;
    logic                no_petal;
  } rcp_out_t;

  // classified word passed from front to back
  typedef struct packed {
    logic                is_step;
    logic [ANGLE_W-1:0]  multiplier;
    logic [ANGLE_W-1:0]  step;
  } rcp_cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } rcp_q_stat_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_GCD_CHK,
    B_GCD,
    B_CNT,
    B_T,
    B_TA0,
    B_TA,
    B_P,
    B_PR,
    B_BS,
    B_LK_R,
    B_LK_S,
    B_LK_C,
    B_MUL1,
    B_MUL2,
    B_MUL3,
    B_OUT
  } rcp_state_t;

  // quarter-wave sine entry in q0.15, taylor series in q30
  function automatic logic [14:0] sin_entry(input int pbits, input int k);
    longint x;
    longint x2;
    longint term;
    longint sum;
    longint v;
    x = (HALF_PI_Q30 * longint'(k)) >>> (pbits - 2);
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    term = ((term * x2) >>> 30) / 6;   sum = sum - term;
    term = ((term * x2) >>> 30) / 20;  sum = sum + term;
    term = ((term * x2) >>> 30) / 42;  sum = sum - term;
    term = ((term * x2) >>> 30) / 72;  sum = sum + term;
    term = ((term * x2) >>> 30) / 110; sum = sum - term;
    term = ((term * x2) >>> 30) / 156; sum = sum + term;
    term = ((term * x2) >>> 30) / 210; sum = sum - term;
    term = ((term * x2) >>> 30) / 272; sum = sum + term;
    term = ((term * x2) >>> 30) / 342; sum = sum - term;
    term = ((term * x2) >>> 30) / 420; sum = sum + term;
    term = ((term * x2) >>> 30) / 506; sum = sum - term;
    term = ((term * x2) >>> 30) / 600; sum = sum + term;
    if (sum < 0) sum = 0;
    v = (sum + 64'sd16384) >>> 15;
    if (v > 64'sd32767) v = 64'sd32767;
    return v[14:0];
  endfunction

endpackage

// ===== hdl/rose_curve_polygon_generator.sv =====
// top level of the rose curve polygon generator
//
//  channel  direction  handshake          word
//  cmd      in         cmd_valid/stall    rcp_in_t: op, multiplier, step
//  res      out        res_valid/stall    rcp_out_t: count, flags, x, y
//  cfg      in         cfg_valid/ready    cfg_index, cfg_data
//
// one word at a time in the back stage; the front and a two-word queue keep taking
// words meanwhile. all divisions share one radix-2 divider of DVW = max(28, 14+PHASE_BITS)
// bits: a vertex runs five of them plus dispatch, rom reads and multiplies; a start
// runs one per gcd remainder step plus one for the count. synchronous reset clears
// control state only; a held result waits in the output register while res_stall is high.
module rose_curve_polygon_generator #(
  parameter int MAX_DIVISIONS = rcp_pkg::DEF_MAX_DIVISIONS,
  parameter int MIN_POINTS = rcp_pkg::DEF_MIN_POINTS,
  parameter int PHASE_BITS = rcp_pkg::DEF_PHASE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  rcp_pkg::rcp_in_t                cmd,
  output logic                            res_valid,
  input  logic                            res_stall,
  output rcp_pkg::rcp_out_t               res,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rcp_pkg::*;

  logic        push;
  rcp_cmd_t    push_word;
  logic        pop;
  rcp_cmd_t    head;
  rcp_q_stat_t q_stat;

  rcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push      (push),
    .push_word (push_word),
    .q_stat    (q_stat)
  );

  rcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  rcp_back #(
    .MAX_DIVISIONS (MAX_DIVISIONS),
    .MIN_POINTS    (MIN_POINTS),
    .PHASE_BITS    (PHASE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_word    (head),
    .q_pop     (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

// ===== hdl/rcp_front.sv =====
// front stage: takes command words, classifies them and pushes them into the queue
module rcp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  rcp_pkg::rcp_in_t  cmd,
  output logic              push,
  output rcp_pkg::rcp_cmd_t push_word,
  input  rcp_pkg::rcp_q_stat_t q_stat
);
  import rcp_pkg::*;

  logic     held;
  rcp_cmd_t word;

  assign cmd_stall = held && q_stat.full;
  assign push = held && !q_stat.full;
  assign push_word = word;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!cmd_stall) begin
      held <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!cmd_stall && cmd_valid) begin
      word.is_step <= (cmd.op == OP_STEP);
      word.multiplier <= cmd.multiplier;
      word.step <= cmd.step;
    end
  end

endmodule

// ===== hdl/rcp_queue.sv =====
// short command queue between front and back
module rcp_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  rcp_pkg::rcp_cmd_t    push_word,
  input  logic                 pop,
  output rcp_pkg::rcp_cmd_t    head,
  output rcp_pkg::rcp_q_stat_t q_stat
);
  import rcp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rcp_cmd_t        entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   fill;

  assign head = entries[rd_ptr];
  assign q_stat.full = (fill == CW'(QUEUE_DEPTH));
  assign q_stat.valid = (fill != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_word;
  end

endmodule

// ===== hdl/rcp_div.sv =====
// radix-2 restoring divider, one quotient bit a cycle
module rcp_div #(
  parameter int DVW = 28
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         go,
  input  logic [DVW-1:0]               num,
  input  logic [rcp_pkg::COUNT_W-1:0]  den,
  output logic                         done,
  output logic [DVW-1:0]               quo,
  output logic [rcp_pkg::COUNT_W-1:0]  rem
);
  import rcp_pkg::*;

  localparam int CW = $clog2(DVW + 1);

  logic                busy;
  logic [CW-1:0]       cnt;
  logic [DVW-1:0]      q;
  logic [COUNT_W-1:0]  r;
  logic [COUNT_W-1:0]  den_q;
  logic [COUNT_W:0]    r_sh;
  logic [COUNT_W:0]    diff;
  logic                ge;

  assign r_sh = {r, q[DVW-1]};
  assign diff = r_sh - {1'b0, den_q};
  assign ge = (r_sh >= {1'b0, den_q});
  assign quo = q;
  assign rem = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= CW'(DVW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q <= num;
      r <= '0;
      den_q <= den;
    end else if (busy) begin
      q <= {q[DVW-2:0], ge};
      r <= ge ? diff[COUNT_W-1:0] : r_sh[COUNT_W-1:0];
    end
  end

endmodule

// ===== hdl/rcp_back.sv =====
// back stage: sequencer for petal setup and vertex generation, sine rom, output register
module rcp_back #(
  parameter int MAX_DIVISIONS = rcp_pkg::DEF_MAX_DIVISIONS,
  parameter int MIN_POINTS = rcp_pkg::DEF_MIN_POINTS,
  parameter int PHASE_BITS = rcp_pkg::DEF_PHASE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rcp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  rcp_pkg::rcp_q_stat_t            q_stat,
  input  rcp_pkg::rcp_cmd_t               q_word,
  output logic                            q_pop,
  output logic                            res_valid,
  input  logic                            res_stall,
  output rcp_pkg::rcp_out_t               res
);
  import rcp_pkg::*;

  localparam int PB = PHASE_BITS;
  localparam int QUARTER = 1 << (PB - 2);
  localparam int AW = PB - 1;
  localparam int DVW = (ANGLE_W + PB > 2 * ANGLE_W) ? ANGLE_W + PB : 2 * ANGLE_W;

  logic [COUNT_W-1:0]  divisions;
  logic [HALF_W-1:0]   half_width;
  logic [HALF_W-1:0]   half_height;
  logic [COUNT_W-1:0]  d;

  rcp_state_t          state;
  rcp_state_t          state_next;

  logic [ANGLE_W-1:0]  angle_index;
  logic [COUNT_W-1:0]  points_left;
  logic [ANGLE_W-1:0]  saved_multiplier;
  logic [ANGLE_W-1:0]  saved_step;

  logic [COUNT_W-1:0]  gm;
  logic [COUNT_W-1:0]  gn;
  logic [COUNT_W-1:0]  dh;
  logic [COUNT_W-1:0]  d_half;
  logic [ANGLE_W-1:0]  t;
  logic [ANGLE_W-1:0]  ta;
  logic [PB-1:0]       ph_p;
  logic [PB-1:0]       ph_r;
  logic [PB-1:0]       lk_ph;
  logic                sgn;
  logic signed [15:0]  val_r;
  logic signed [15:0]  val_s;
  logic signed [15:0]  val_c;
  logic signed [15:0]  rom_val;
  logic signed [31:0]  sr;
  logic signed [31:0]  cr;
  logic [2*ANGLE_W-1:0] prod_ta;
  logic [COUNT_W-1:0]  angle_sum;
  rcp_out_t            res_word;
  rcp_out_t            res_hold;
  logic                res_load;

  logic                div_go;
  logic [DVW-1:0]      div_num;
  logic [COUNT_W-1:0]  div_den;
  logic                div_done;
  logic [DVW-1:0]      div_quo;
  logic [COUNT_W-1:0]  div_rem;

  logic [14:0]         tab [2**AW];
  logic [AW-1:0]       rom_addr;
  logic [14:0]         rom_q;

  for (genvar k = 0; k < 2**AW; k++) begin : g_tab
    if (k <= QUARTER) begin : g_used
      assign tab[k] = sin_entry(PB, k);
    end else begin : g_pad
      assign tab[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    rom_q <= tab[rom_addr];
  end

  rcp_div #(.DVW(DVW)) u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // clamp the division count into its usable range
  always_comb begin
    if (divisions > COUNT_W'(MAX_DIVISIONS)) d = COUNT_W'(MAX_DIVISIONS);
    else if (divisions == '0) d = COUNT_W'(1);
    else d = divisions;
  end

  // odd a and b on an even count trace each petal twice
  assign d_half = (q_word.multiplier[0] && q_word.step[0] && !d[0]) ? (d >> 1) : d;
  assign prod_ta = t * saved_multiplier;
  assign angle_sum = {1'b0, t} + div_rem;
  assign cfg_ready = 1'b1;
  assign res = res_hold;
  assign rom_val = $signed({1'b0, rom_q});

  // fold a phase into a quarter-wave table address
  function automatic logic [AW-1:0] addr_of(input logic [PB-1:0] ph);
    logic [AW-1:0] low;
    low = AW'(ph[PB-3:0]);
    return ph[PB-2] ? (AW'(QUARTER) - low) : low;
  endfunction

  function automatic logic [COORD_W-1:0] coord(input logic signed [31:0] prod,
                                               input logic [HALF_W-1:0] half);
    logic signed [46:0] tot;
    tot = prod * $signed({1'b0, half}) + $signed({5'b0, half, 30'b0});
    return tot[46] ? '0 : tot[42:30];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    div_go = 1'b0;
    div_num = '0;
    div_den = d;
    lk_ph = ph_p;
    rom_addr = '0;
    res_load = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_stat.valid) begin
          q_pop = 1'b1;
          if (!q_word.is_step) begin
            state_next = B_GCD_CHK;
          end else if (points_left == '0) begin
            state_next = B_OUT;
          end else begin
            div_go = 1'b1;
            div_num = DVW'(angle_index);
            state_next = B_T;
          end
        end
      end
      B_GCD_CHK: begin
        div_go = 1'b1;
        if (gn == '0) begin
          div_num = DVW'(dh);
          div_den = gm;
          state_next = B_CNT;
        end else begin
          div_num = DVW'(gm);
          div_den = gn;
          state_next = B_GCD;
        end
      end
      B_GCD: if (div_done) state_next = B_GCD_CHK;
      B_CNT: if (div_done) state_next = B_OUT;
      B_T: if (div_done) state_next = B_TA0;
      B_TA0: begin
        div_go = 1'b1;
        div_num = DVW'(prod_ta);
        state_next = B_TA;
      end
      B_TA: begin
        if (div_done) begin
          div_go = 1'b1;
          div_num = DVW'({t, {PB{1'b0}}});
          state_next = B_P;
        end
      end
      B_P: begin
        if (div_done) begin
          div_go = 1'b1;
          div_num = DVW'({ta, {PB{1'b0}}});
          state_next = B_PR;
        end
      end
      B_PR: begin
        if (div_done) begin
          div_go = 1'b1;
          div_num = DVW'(saved_step);
          state_next = B_BS;
        end
      end
      B_BS: if (div_done) state_next = B_LK_R;
      B_LK_R: begin
        lk_ph = ph_r;
        rom_addr = addr_of(lk_ph);
        state_next = B_LK_S;
      end
      B_LK_S: begin
        lk_ph = ph_p;
        rom_addr = addr_of(lk_ph);
        state_next = B_LK_C;
      end
      B_LK_C: begin
        lk_ph = ph_p + PB'(QUARTER);
        rom_addr = addr_of(lk_ph);
        state_next = B_MUL1;
      end
      B_MUL1: state_next = B_MUL2;
      B_MUL2: state_next = B_MUL3;
      B_MUL3: state_next = B_OUT;
      B_OUT: begin
        if (!res_valid || !res_stall) begin
          res_load = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divisions <= DIVISIONS_RESET;
      half_width <= HALF_WIDTH_RESET;
      half_height <= HALF_HEIGHT_RESET;
      angle_index <= '0;
      points_left <= '0;
      saved_multiplier <= '0;
      saved_step <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_DIVISIONS: divisions <= cfg_data;
          CFG_HALF_WIDTH: half_width <= cfg_data[HALF_W-1:0];
          CFG_HALF_HEIGHT: half_height <= cfg_data[HALF_W-1:0];
          default: ;
        endcase
      end
      if (res_load) res_valid <= 1'b1;
      else if (res_valid && !res_stall) res_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (q_stat.valid && !q_word.is_step) begin
            saved_multiplier <= q_word.multiplier;
            saved_step <= q_word.step;
            angle_index <= '0;
          end
        end
        B_CNT: begin
          if (div_done) begin
            if (div_quo[COUNT_W-1:0] < COUNT_W'(MIN_POINTS)) points_left <= '0;
            else points_left <= div_quo[COUNT_W-1:0];
          end
        end
        B_BS: begin
          if (div_done) begin
            if (angle_sum >= d) angle_index <= ANGLE_W'(angle_sum - d);
            else angle_index <= angle_sum[ANGLE_W-1:0];
            points_left <= points_left - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // finished word is copied out so work on the next one leaves it untouched
  always_ff @(posedge clk) begin
    if (res_load) res_hold <= res_word;
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_stat.valid) begin
          if (!q_word.is_step) begin
            res_word <= '0;
            dh <= d_half;
            gm <= d_half;
            gn <= {1'b0, q_word.step};
          end else if (points_left == '0) begin
            res_word <= '{no_petal: 1'b1, default: '0};
          end else begin
            res_word <= '0;
          end
        end
      end
      B_GCD: begin
        if (div_done) begin
          gm <= gn;
          gn <= div_rem;
        end
      end
      B_CNT: begin
        if (div_done) begin
          res_word.point_count <= div_quo[COUNT_W-1:0];
          res_word.too_few <= (div_quo[COUNT_W-1:0] < COUNT_W'(MIN_POINTS));
        end
      end
      B_T: if (div_done) t <= div_rem[ANGLE_W-1:0];
      B_TA: if (div_done) ta <= div_rem[ANGLE_W-1:0];
      B_P: if (div_done) ph_p <= div_quo[PB-1:0];
      B_PR: if (div_done) ph_r <= div_quo[PB-1:0];
      B_BS: if (div_done) res_word.last <= (points_left == COUNT_W'(1));
      B_LK_R: sgn <= lk_ph[PB-1];
      B_LK_S: begin
        val_r <= sgn ? -rom_val : rom_val;
        sgn <= lk_ph[PB-1];
      end
      B_LK_C: begin
        val_s <= sgn ? -rom_val : rom_val;
        sgn <= lk_ph[PB-1];
      end
      B_MUL1: begin
        val_c <= sgn ? -rom_val : rom_val;
        sr <= val_s * val_r;
      end
      B_MUL2: cr <= val_c * val_r;
      B_MUL3: begin
        res_word.x_coord <= coord(sr, half_width);
        res_word.y_coord <= coord(cr, half_height);
      end
      default: ;
    endcase
  end

endmodule

// ===== dv/rose_curve_polygon_generator_test.sv =====
// testbench for the rose curve polygon generator: predicted vertices and counts checked word by word
module rose_curve_polygon_generator_test;
  import rcp_pkg::*;

  localparam int QTR = 1 << (DEF_PHASE_BITS - 2);
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  rcp_in_t cmd = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  rcp_out_t res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  rose_curve_polygon_generator dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow state of the generator
  int unsigned div_reg, wid_reg, hgt_reg;
  int unsigned theta, pts_left, petal_a, petal_b;
  int quarter_sine [0:QTR];
  rcp_out_t vertex_q [$];
  int errors = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  int quiet = 0;

  task automatic build_sine();
    longint x, x2, term, acc, v;
    for (int k = 0; k <= QTR; k++) begin
      x = (64'sd1686629713 * k) / QTR;
      x2 = (x * x) >>> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >>> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2) acc -= term;
        else acc += term;
      end
      if (acc < 0) acc = 0;
      v = (acc + 16384) >>> 15;
      if (v > 32767) v = 32767;
      quarter_sine[k] = int'(v);
    end
  endtask

  function automatic longint sine_of(int unsigned p);
    int unsigned quad, rem;
    longint m;
    quad = (p >> (DEF_PHASE_BITS - 2)) & 3;
    rem = p & (QTR - 1);
    m = (quad & 1) ? quarter_sine[QTR - rem] : quarter_sine[rem];
    return (quad & 2) ? -m : m;
  endfunction

  function automatic int unsigned phase_of(int unsigned t, int unsigned d);
    return int'((longint'(t % d) << DEF_PHASE_BITS) / d);
  endfunction

  function automatic logic [COORD_W-1:0] pixel(longint sr, int unsigned half);
    longint total;
    total = sr * half + (longint'(half) << 30);
    if (total < 0) total = 0;
    return total[30 +: COORD_W];
  endfunction

  // advance the shadow state by one word and return the expected result
  function automatic rcp_out_t rose_next(rcp_in_t w);
    rcp_out_t o;
    int unsigned d, dh, m, n, r, t, ta, p;
    longint rr, s, c;
    o = '0;
    d = div_reg > DEF_MAX_DIVISIONS ? DEF_MAX_DIVISIONS : div_reg;
    if (d == 0) d = 1;
    if (w.op == OP_START) begin
      dh = d;
      if (w.multiplier[0] && w.step[0] && !dh[0]) dh = dh / 2;
      m = dh;
      n = 32'(w.step);
      while (n != 0) begin
        r = m % n;
        m = n;
        n = r;
      end
      petal_a = 32'(w.multiplier);
      petal_b = 32'(w.step);
      theta = 0;
      o.point_count = COUNT_W'(dh / m);
      if (dh / m < DEF_MIN_POINTS) begin
        o.too_few = 1'b1;
        pts_left = 0;
      end else begin
        pts_left = dh / m;
      end
    end else if (pts_left == 0) begin
      o.no_petal = 1'b1;
    end else begin
      t = theta % d;
      ta = (t * petal_a) % d;
      rr = sine_of(phase_of(ta, d));
      p = phase_of(t, d);
      s = sine_of(p);
      c = sine_of((p + QTR) & ((1 << DEF_PHASE_BITS) - 1));
      o.x_coord = pixel(s * rr, wid_reg);
      o.y_coord = pixel(c * rr, hgt_reg);
      pts_left = pts_left - 1;
      o.last = (pts_left == 0);
      theta = ((t + petal_b % d) % d) & 16'h3fff;
    end
    return o;
  endfunction

  task automatic send_word(rcp_in_t w);
    while ($urandom_range(99) < snd_idle) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    vertex_q.push_back(rose_next(w));
  endtask

  task automatic send_start(int unsigned a, int unsigned b);
    rcp_in_t w;
    w.op = OP_START;
    w.multiplier = ANGLE_W'(a);
    w.step = ANGLE_W'(b);
    send_word(w);
  endtask

  task automatic send_steps(int num);
    rcp_in_t w;
    for (int i = 0; i < num; i++) begin
      w.op = OP_STEP;
      w.multiplier = ANGLE_W'($urandom_range(16383));
      w.step = ANGLE_W'($urandom_range(16383));
      send_word(w);
    end
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DIVISIONS: div_reg = val & 16'h7fff;
      CFG_HALF_WIDTH: wid_reg = val & 12'hfff;
      default: hgt_reg = val & 12'hfff;
    endcase
  endtask

  task automatic test_directed();
    send_steps(1);                 // step with no petal
    send_start(1, 1);              // odd a and b halve the circle
    send_steps(4);
    send_start(0, 7);              // zero multiplier stays at center
    send_steps(2);
    send_start(3, 0);              // zero step
    send_steps(2);
    send_start(2, 180);            // too few points
    send_steps(1);
    send_start(16383, 16383);
    send_steps(3);
    send_start(5, 72);             // exactly the minimum, run to last
    send_steps(6);
  endtask

  task automatic test_registers();
    write_reg(CFG_DIVISIONS, 16384);
    write_reg(CFG_HALF_WIDTH, 4095);
    write_reg(CFG_HALF_HEIGHT, 4095);
    send_start(16383, 16381);
    send_steps(3);
    write_reg(CFG_DIVISIONS, 32767);   // above the maximum
    send_start(7, 4096);
    send_steps(5);
    write_reg(CFG_DIVISIONS, 0);       // used as one
    send_start(1, 1);
    send_steps(1);
    write_reg(CFG_DIVISIONS, 5);
    write_reg(CFG_HALF_WIDTH, 0);
    write_reg(CFG_HALF_HEIGHT, 0);
    send_start(2, 1);
    send_steps(2);
    write_reg(CFG_DIVISIONS, 12);      // divisions change while a petal runs
    send_steps(4);
  endtask

  task automatic random_petals(int num);
    int sent;
    int run;
    int unsigned a, b;
    sent = 0;
    while (sent < num) begin
      if ($urandom_range(9) == 0) begin
        send_steps(1);
        sent++;
      end else begin
        a = $urandom_range(1) ? $urandom_range(16383) : $urandom_range(12);
        b = $urandom_range(1) ? $urandom_range(16383) : $urandom_range(40);
        send_start(a, b);
        sent++;
        run = int'($urandom_range(1, 30));
        send_steps(run);
        sent += run;
      end
    end
  endtask

  task automatic test_random();
    snd_idle = 22;
    rcv_idle = 69;
    write_reg(CFG_DIVISIONS, 360);
    write_reg(CFG_HALF_WIDTH, 320);
    write_reg(CFG_HALF_HEIGHT, 240);
    random_petals(380);
    snd_idle = 69;
    rcv_idle = 22;
    write_reg(CFG_DIVISIONS, $urandom_range(5, 200));
    write_reg(CFG_HALF_WIDTH, $urandom_range(4095));
    write_reg(CFG_HALF_HEIGHT, $urandom_range(4095));
    random_petals(380);
    snd_idle = 0;
    rcv_idle = 0;
    write_reg(CFG_DIVISIONS, $urandom_range(5, 16384));
    write_reg(CFG_HALF_WIDTH, $urandom_range(4095));
    write_reg(CFG_HALF_HEIGHT, $urandom_range(4095));
    random_petals(380);
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    rcp_out_t e;
    if (!rst && res_valid && !res_stall) begin
      if (vertex_q.size() == 0) begin
        $error("unexpected result word %h", res);
        errors++;
      end else begin
        e = vertex_q.pop_front();
        if (res.point_count !== e.point_count) begin
          $error("point_count expected %0d got %0d", e.point_count, res.point_count);
          errors++;
        end
        if (res.too_few !== e.too_few) begin
          $error("too_few expected %0d got %0d", e.too_few, res.too_few);
          errors++;
        end
        if (res.x_coord !== e.x_coord) begin
          $error("x_coord expected %0d got %0d", e.x_coord, res.x_coord);
          errors++;
        end
        if (res.y_coord !== e.y_coord) begin
          $error("y_coord expected %0d got %0d", e.y_coord, res.y_coord);
          errors++;
        end
        if (res.last !== e.last) begin
          $error("last expected %0d got %0d", e.last, res.last);
          errors++;
        end
        if (res.no_petal !== e.no_petal) begin
          $error("no_petal expected %0d got %0d", e.no_petal, res.no_petal);
          errors++;
        end
      end
    end
    res_stall <= ($urandom_range(99) < rcv_idle);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)
        || rst || (vertex_q.size() == 0 && !cmd_valid && !cfg_valid)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    build_sine();
    div_reg = DIVISIONS_RESET;
    wid_reg = HALF_WIDTH_RESET;
    hgt_reg = HALF_HEIGHT_RESET;
    theta = 0;
    pts_left = 0;
    petal_a = 0;
    petal_b = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();                       // sender holds off until every result is back
    test_registers();
    test_random();
    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
